// ----- sv/xoshiro_pkg.sv -----
package xoshiro_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Words   = 4;
  localparam int unsigned PolyW   = WordW * Words;
  localparam int unsigned BitIdxW = $clog2(PolyW);
  localparam int unsigned WordIdxW = $clog2(Words);

  typedef logic [WordW-1:0] word_t;
  typedef word_t [Words-1:0] state_t;

  // Action codes carried in the input tuser field
  typedef enum logic [1:0] {
    ACT_DRAW      = 2'd0,
    ACT_SEED      = 2'd1,
    ACT_JUMP      = 2'd2,
    ACT_LONG_JUMP = 2'd3
  } action_e;

  localparam word_t MixGolden = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t MixMulA   = 64'hBF58_476D_1CE4_E5B9;
  localparam word_t MixMulB   = 64'h94D0_49BB_1331_11EB;

  // Jump polynomials, word 0 in the lowest bits
  localparam logic [PolyW-1:0] JumpPoly = {
    64'h39ab_dc45_29b1_661c, 64'ha958_2618_e03f_c9aa,
    64'hd5a6_1266_f0c9_392c, 64'h180e_c6d3_3cfd_0aba};
  localparam logic [PolyW-1:0] LongJumpPoly = {
    64'h3910_9bb0_2acb_e635, 64'h7771_0069_854e_e241,
    64'hc500_4e44_1c52_2fb3, 64'h76e1_5d3e_fefd_cbbf};

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DRAW,
    OP_SEED_LOAD,
    OP_SEED_ADD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MIX,
    OP_SEED_WR,
    OP_JUMP_STEP,
    OP_JUMP_LOAD,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic                mul_pass;   // 0: first SplitMix multiplier, 1: second
    logic [WordIdxW-1:0] word_idx;
    logic [BitIdxW-1:0]  bit_idx;
    logic                far_sel;    // 1: long jump polynomial
  } xo_cmd_t;

  // One xoshiro256 state step
  function automatic state_t xo_advance(state_t w);
    state_t n;
    word_t  t;
    t    = w[1] << 17;
    n    = w;
    n[2] = w[2] ^ w[0];
    n[3] = w[3] ^ w[1];
    n[1] = w[1] ^ n[2];
    n[0] = w[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = {n[3][18:0], n[3][63:19]};
    return n;
  endfunction

endpackage

// ----- sv/xoshiro_dp.sv -----
module xoshiro_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  xoshiro_pkg::xo_cmd_t cmd_i,
  input  xoshiro_pkg::word_t   seed_i,
  output xoshiro_pkg::word_t   random_value_o,
  output logic                 is_draw_o
);

  xoshiro_pkg::state_t w_q, w_d;
  xoshiro_pkg::state_t jacc_q, jacc_d;
  xoshiro_pkg::word_t  m5_q, m5_d;     // generator word 1 times 5
  xoshiro_pkg::word_t  acc_q, acc_d;   // SplitMix counter
  xoshiro_pkg::word_t  z_q, z_d;
  xoshiro_pkg::word_t  prod_q, prod_d;
  xoshiro_pkg::word_t  rv_q, rv_d;
  logic                isd_q, isd_d;

  xoshiro_pkg::word_t  adv_w1;
  xoshiro_pkg::state_t adv;
  xoshiro_pkg::word_t  rot7;
  xoshiro_pkg::word_t  mul_c;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         mul_p;
  logic                poly_bit;

  assign adv   = xoshiro_pkg::xo_advance(w_q);
  assign rot7  = {m5_q[56:0], m5_q[63:57]};
  assign mul_c = cmd_i.mul_pass ? xoshiro_pkg::MixMulB : xoshiro_pkg::MixMulA;
  assign poly_bit = cmd_i.far_sel ? xoshiro_pkg::LongJumpPoly[cmd_i.bit_idx]
                                  : xoshiro_pkg::JumpPoly[cmd_i.bit_idx];

  // 64x64 low product built from three 32x32 partials, one per multiply step
  always_comb begin
    unique case (cmd_i.op)
      xoshiro_pkg::OP_MUL1: begin
        mul_a = z_q[63:32];
        mul_b = mul_c[31:0];
      end
      xoshiro_pkg::OP_MUL2: begin
        mul_a = z_q[31:0];
        mul_b = mul_c[63:32];
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    w_d    = w_q;
    jacc_d = jacc_q;
    acc_d  = acc_q;
    z_d    = z_q;
    prod_d = prod_q;
    rv_d   = rv_q;
    isd_d  = isd_q;
    unique case (cmd_i.op)
      xoshiro_pkg::OP_DRAW: begin
        w_d   = adv;
        rv_d  = (rot7 << 3) + rot7;
        isd_d = 1'b1;
      end
      xoshiro_pkg::OP_SEED_LOAD: acc_d = seed_i;
      xoshiro_pkg::OP_SEED_ADD: begin
        acc_d = acc_q + xoshiro_pkg::MixGolden;
        z_d   = acc_d ^ (acc_d >> 30);
      end
      xoshiro_pkg::OP_MUL0: prod_d = mul_p;
      xoshiro_pkg::OP_MUL1, xoshiro_pkg::OP_MUL2:
        prod_d = prod_q + {mul_p[31:0], 32'd0};
      xoshiro_pkg::OP_MIX: z_d = prod_q ^ (prod_q >> 27);
      xoshiro_pkg::OP_SEED_WR: w_d[cmd_i.word_idx] = prod_q ^ (prod_q >> 31);
      xoshiro_pkg::OP_JUMP_STEP: begin
        for (int k = 0; k < xoshiro_pkg::Words; k++) begin
          jacc_d[k] = ((cmd_i.bit_idx == '0) ? '0 : jacc_q[k]) ^
                      (poly_bit ? w_q[k] : '0);
        end
        w_d = adv;
      end
      xoshiro_pkg::OP_JUMP_LOAD: w_d = jacc_q;
      xoshiro_pkg::OP_RESULT: begin
        rv_d  = '0;
        isd_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign adv_w1 = w_d[1];
  assign m5_d   = (adv_w1 << 2) + adv_w1;

  // counter starts at zero so the power-up pass expands seed zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    m5_q   <= m5_d;
    jacc_q <= jacc_d;
    z_q    <= z_d;
    prod_q <= prod_d;
    rv_q   <= rv_d;
    isd_q  <= isd_d;
  end

  assign random_value_o = rv_q;
  assign is_draw_o      = isd_q;

endmodule

// ----- sv/xoshiro_ctrl.sv -----
module xoshiro_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           action_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output xoshiro_pkg::xo_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MIX,
    S_WR,
    S_JUMP,
    S_LOAD,
    S_FIN
  } state_e;

  state_e                                state_q;
  logic                                  pass_q;
  logic                                  pend_q;
  logic                                  lj_q;
  logic                                  ov_q;
  logic [xoshiro_pkg::WordIdxW-1:0]      idx_q;
  logic [xoshiro_pkg::BitIdxW-1:0]       bit_q;
  logic                                  accept;
  xoshiro_pkg::action_e                  act;

  assign act        = xoshiro_pkg::action_e'(action_i);
  assign in_ready_o = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o.mul_pass  = pass_q;
    cmd_o.word_idx  = idx_q;
    cmd_o.bit_idx   = bit_q;
    cmd_o.far_sel   = lj_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && act == xoshiro_pkg::ACT_DRAW) begin
          cmd_o.op = xoshiro_pkg::OP_DRAW;
        end else if (accept && act == xoshiro_pkg::ACT_SEED) begin
          cmd_o.op = xoshiro_pkg::OP_SEED_LOAD;
        end else begin
          cmd_o.op = xoshiro_pkg::OP_NOP;
        end
      end
      S_ADD:  cmd_o.op = xoshiro_pkg::OP_SEED_ADD;
      S_MUL0: cmd_o.op = xoshiro_pkg::OP_MUL0;
      S_MUL1: cmd_o.op = xoshiro_pkg::OP_MUL1;
      S_MUL2: cmd_o.op = xoshiro_pkg::OP_MUL2;
      S_MIX:  cmd_o.op = xoshiro_pkg::OP_MIX;
      S_WR:   cmd_o.op = xoshiro_pkg::OP_SEED_WR;
      S_JUMP: cmd_o.op = xoshiro_pkg::OP_JUMP_STEP;
      S_LOAD: cmd_o.op = xoshiro_pkg::OP_JUMP_LOAD;
      S_FIN:  cmd_o.op = xoshiro_pkg::OP_RESULT;
      default: cmd_o.op = xoshiro_pkg::OP_NOP;
    endcase
  end

  // reset enters the seeding sequence with nothing owed to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ADD;
      pass_q  <= 1'b0;
      pend_q  <= 1'b0;
      lj_q    <= 1'b0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      bit_q   <= '0;
    end else begin
      if ((accept && (act == xoshiro_pkg::ACT_DRAW)) || (state_q == S_FIN)) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (act)
              xoshiro_pkg::ACT_DRAW: state_q <= S_IDLE;
              xoshiro_pkg::ACT_SEED: begin
                idx_q   <= '0;
                pass_q  <= 1'b0;
                pend_q  <= 1'b1;
                state_q <= S_ADD;
              end
              default: begin
                bit_q   <= '0;
                lj_q    <= (act == xoshiro_pkg::ACT_LONG_JUMP);
                state_q <= S_JUMP;
              end
            endcase
          end
        end
        S_ADD:  state_q <= S_MUL0;
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= pass_q ? S_WR : S_MIX;
        S_MIX: begin
          pass_q  <= 1'b1;
          state_q <= S_MUL0;
        end
        S_WR: begin
          pass_q <= 1'b0;
          idx_q  <= idx_q + xoshiro_pkg::WordIdxW'(1);
          if (idx_q == xoshiro_pkg::WordIdxW'(xoshiro_pkg::Words - 1)) begin
            state_q <= pend_q ? S_FIN : S_IDLE;
          end else begin
            state_q <= S_ADD;
          end
        end
        S_JUMP: begin
          bit_q <= bit_q + xoshiro_pkg::BitIdxW'(1);
          if (bit_q == xoshiro_pkg::BitIdxW'(xoshiro_pkg::PolyW - 1)) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: state_q <= S_FIN;
        S_FIN: begin
          pend_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/xoshiro256_starstar_generator.sv -----
// xoshiro256** generator with SplitMix64 seeding and jump / long jump.
// Input stream: tuser carries the action (draw, seed, jump, long jump),
// tdata the 64-bit seed, used by the seed action only. Output stream: one
// transaction per input transaction, tdata the drawn value (zero for seed
// and jumps), tuser set for a draw.
// Draws run at one per cycle while the output is not stalled; the result
// appears in the cycle after the input transaction. The draw output comes
// from a register holding word 1 times five, so a draw costs one shift-add
// on the output path. A seed runs four SplitMix64 rounds, each an add, a
// multiply, a mix, a second multiply and a word write, one shared 32x32
// multiplier building each 64-bit product in three steps. Jump and long
// jump run one generator step per polynomial bit (256), a load and a result.
// After reset the block expands seed zero with s_axis_tready low; no output
// transaction comes from it.
// The result sits in an output register; a new transaction is taken while
// it waits only if the receiver takes it in the same cycle. A stall on the
// output holds s_axis_tready low.
module xoshiro256_starstar_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] seed_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] random_value
  output logic        m_axis_tuser    // [0] is_draw
);

  xoshiro_pkg::xo_cmd_t cmd;

  xoshiro_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .action_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  xoshiro_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .seed_i         (s_axis_tdata),
    .random_value_o (m_axis_tdata),
    .is_draw_o      (m_axis_tuser)
  );

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while output register is occupied");

  a_nondraw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser != 2'(xoshiro_pkg::ACT_DRAW))
    |=> !s_axis_tready)
    else $error("seed or jump did not stall the input");

  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == 2'(xoshiro_pkg::ACT_DRAW))
    |=> (m_axis_tvalid && m_axis_tuser))
    else $error("draw result missing");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("non-draw result carries a value");

endmodule

// ----- tb/xoshiro256_starstar_generator_tb.sv -----
`timescale 1ns / 100ps

module xoshiro256_starstar_generator_tb;

  localparam logic [255:0] JUMP_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
  localparam logic [255:0] LONG_JUMP_POLY = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};
  localparam int unsigned RANDOM_ITEMS = 1000;

  typedef struct {
    xoshiro_pkg::action_e act;
    xoshiro_pkg::word_t   seed;
    int unsigned          gap;
    bit                   drain;   // hold this one back until all results are in
  } rng_request_t;

  typedef struct {
    xoshiro_pkg::word_t value;
    logic               is_draw;
  } rng_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] seed_value
  logic [1:0]  s_axis_tuser = xoshiro_pkg::ACT_DRAW;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;   // [63:0] random_value
  logic        m_axis_tuser;   // [0] is_draw

  rng_request_t        requests_q[$];
  rng_result_t         results_due[$];
  rng_request_t        next_req;
  rng_result_t         model_res;
  rng_result_t         want;
  xoshiro_pkg::state_t gen_state;
  int unsigned         hold_cnt;
  int unsigned         stall_cnt;
  int unsigned         stall_nxt;
  int unsigned         total_reqs;
  int unsigned         accepted_cnt;
  int unsigned         checked_cnt;
  int unsigned         err_cnt;
  int unsigned         act_cnt[4];

  xoshiro256_starstar_generator dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  function automatic xoshiro_pkg::word_t rotl64(xoshiro_pkg::word_t x, int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic xoshiro_pkg::state_t seed_words(xoshiro_pkg::word_t seed);
    xoshiro_pkg::state_t w;
    xoshiro_pkg::word_t  acc;
    xoshiro_pkg::word_t  z;
    acc = seed;
    for (int i = 0; i < 4; i++) begin
      acc = acc + 64'h9E3779B97F4A7C15;
      z = acc;
      z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
      z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
      w[i] = z ^ (z >> 31);
    end
    return w;
  endfunction

  function automatic xoshiro_pkg::word_t starstar_out(xoshiro_pkg::state_t w);
    xoshiro_pkg::word_t times5;
    xoshiro_pkg::word_t rot;
    times5 = w[1] * 64'd5;
    rot = rotl64(times5, 7);
    return rot * 64'd9;
  endfunction

  function automatic xoshiro_pkg::state_t step_words(xoshiro_pkg::state_t w);
    xoshiro_pkg::word_t shl;
    shl = w[1] << 17;
    w[2] = w[2] ^ w[0];
    w[3] = w[3] ^ w[1];
    w[1] = w[1] ^ w[2];
    w[0] = w[0] ^ w[3];
    w[2] = w[2] ^ shl;
    w[3] = rotl64(w[3], 45);
    return w;
  endfunction

  // Sum of the states selected by the polynomial bits, word 0 bit 0 first
  function automatic xoshiro_pkg::state_t jump_words(xoshiro_pkg::state_t w,
                                                     logic [255:0] poly);
    xoshiro_pkg::state_t acc;
    acc = '0;
    for (int b = 0; b < 256; b++) begin
      if (poly[b]) begin
        for (int k = 0; k < 4; k++) acc[k] = acc[k] ^ w[k];
      end
      w = step_words(w);
    end
    return acc;
  endfunction

  // Driver: one transaction per queued request, with a per-request gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= xoshiro_pkg::ACT_DRAW;
      hold_cnt      <= 0;
      gen_state     = seed_words(64'd0);
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        model_res.value   = '0;
        model_res.is_draw = 1'b0;
        case (xoshiro_pkg::action_e'(s_axis_tuser))
          xoshiro_pkg::ACT_DRAW: begin
            model_res.value   = starstar_out(gen_state);
            model_res.is_draw = 1'b1;
            gen_state = step_words(gen_state);
          end
          xoshiro_pkg::ACT_SEED: begin
            gen_state = seed_words(s_axis_tdata);
          end
          xoshiro_pkg::ACT_JUMP: begin
            gen_state = jump_words(gen_state, JUMP_POLY);
          end
          default: begin
            gen_state = jump_words(gen_state, LONG_JUMP_POLY);
          end
        endcase
        results_due.push_back(model_res);
        act_cnt[s_axis_tuser]++;
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (requests_q.size() == 0 || hold_cnt != 0 ||
            (requests_q[0].drain && results_due.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
          if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
        end else begin
          next_req = requests_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_req.seed;
          s_axis_tuser  <= next_req.act;
          hold_cnt      <= next_req.gap;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, got value %h draw %b",
                   $time, m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          want = results_due.pop_front();
          if (m_axis_tdata !== want.value) begin
            $display("%0t: random_value mismatch, expected %h, actual %h",
                     $time, want.value, m_axis_tdata);
            err_cnt++;
          end
          if (m_axis_tuser !== want.is_draw) begin
            $display("%0t: is_draw mismatch, expected %b, actual %b",
                     $time, want.is_draw, m_axis_tuser);
            err_cnt++;
          end
        end
        checked_cnt++;
        // every third stretch of 128 results runs without back-pressure
        stall_nxt = ((checked_cnt / 128) % 3 == 0) ? 0 : $urandom_range(0, 10);
      end else begin
        stall_nxt = (stall_cnt != 0) ? stall_cnt - 1 : 0;
      end
      stall_cnt     <= stall_nxt;
      m_axis_tready <= (stall_nxt == 0);
    end
  end

  task automatic queue_request(xoshiro_pkg::action_e act, xoshiro_pkg::word_t seed,
                               int unsigned gap, bit drain);
    rng_request_t r;
    r.act   = act;
    r.seed  = seed;
    r.gap   = gap;
    r.drain = drain;
    requests_q.push_back(r);
    total_reqs++;
  endtask

  initial begin
    int unsigned          pick;
    xoshiro_pkg::action_e act;
    bit                   calm;

    // Draws straight from the power-up seed, seed field ignored on draws
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, '1, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'h0123_4567_89ab_cdef, 3, 1'b0);
    // Seed extremes
    queue_request(xoshiro_pkg::ACT_SEED, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_SEED, '1, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_SEED, 64'h8000_0000_0000_0000, 2, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_SEED, 64'd1, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_SEED, 64'h5555_5555_5555_5555, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_SEED, 64'haaaa_aaaa_aaaa_aaaa, 0, 1'b0);
    // Jumps, with junk on the seed field, back to back and with draws between
    queue_request(xoshiro_pkg::ACT_JUMP, '1, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_LONG_JUMP, 64'hdead_beef_cafe_f00d, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_JUMP, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_LONG_JUMP, 64'd0, 0, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, '1, 5, 1'b0);
    queue_request(xoshiro_pkg::ACT_DRAW, 64'd0, 0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 84) act = xoshiro_pkg::ACT_DRAW;
      else if (pick < 92) act = xoshiro_pkg::ACT_SEED;
      else if (pick < 96) act = xoshiro_pkg::ACT_JUMP;
      else act = xoshiro_pkg::ACT_LONG_JUMP;
      calm = ((n / 64) % 3 == 1);
      queue_request(act, {$urandom, $urandom}, calm ? 0 : $urandom_range(0, 10),
                    n == 0 || $urandom_range(0, 99) == 0);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_cnt != total_reqs) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d draws, %0d seeds, %0d jumps, %0d long jumps",
             act_cnt[xoshiro_pkg::ACT_DRAW], act_cnt[xoshiro_pkg::ACT_SEED],
             act_cnt[xoshiro_pkg::ACT_JUMP], act_cnt[xoshiro_pkg::ACT_LONG_JUMP]);
    $display("%0d results checked with random gaps and back-pressure, %0d errors",
             checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("xoshiro256_starstar_generator_tb: clean");
    end else begin
      $display("xoshiro256_starstar_generator_tb: errors");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout at %0t", $time);
    $display("xoshiro256_starstar_generator_tb: errors");
    $finish;
  end

endmodule

// ----- xoshiro256_starstar_generator.f -----
sv/xoshiro_pkg.sv
sv/xoshiro_dp.sv
sv/xoshiro_ctrl.sv
sv/xoshiro256_starstar_generator.sv
tb/xoshiro256_starstar_generator_tb.sv
